@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types for the sensor frame receiver: frame headers,
// register indexes and result frame types.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int unsigned DEFAULT_BUFFER_DEPTH = 20;
    localparam int unsigned KEPT_BYTES           = 5;
    localparam int unsigned CODE_BYTES           = 4;
    localparam int unsigned COUNT_W              = 5;
    localparam int unsigned CFG_INDEX_W          = 8;
    localparam int unsigned CFG_DATA_W           = 16;
    localparam int unsigned DIST_W               = 16;

    localparam logic [7:0] HDR_CODE = 8'h55;
    localparam logic [7:0] HDR_DIST = 8'hFF;

    localparam logic [15:0] JUMP_LIMIT_RESET = 16'd80;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_JUMP_LIMIT    = 8'd1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_IDLE = 1'b1;

    typedef enum logic [2:0] {
        FT_CODE      = 3'd0,
        FT_DIST_OK   = 3'd1,
        FT_DIST_DROP = 3'd2,
        FT_SUM_BAD   = 3'd3,
        FT_UNKNOWN   = 3'd4
    } t_frame_type;

endpackage

@@ rtl/sensor_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_receiver_top
// Collects received UART bytes into a five-byte frame store and decodes the
// frame on each line-idle transaction into one registered result.
// ----------------------------------------------------------------------------
// One transaction per clock: a byte transaction updates the frame store in
// the cycle it is accepted and yields no result; an idle transaction is
// decoded by combinational logic into the output register and its result is
// offered on the next cycle. Byte transactions are taken even while a result
// waits; an idle transaction waits only while an untaken result sits in the
// output register. The frame store is not cleared between frames, so a short
// frame decodes bytes left from earlier ones. Configuration writes are always
// ready and take effect at once; indexes beyond the register list are ignored.
module sensor_frame_receiver_top #(
    parameter int unsigned BUFFER_DEPTH = sfr_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_kind,
    input  logic [7:0]                      i_rx_byte,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_frame_type,
    output logic [7:0]                      o_code_byte0,
    output logic [7:0]                      o_code_byte1,
    output logic [7:0]                      o_code_byte2,
    output logic [7:0]                      o_code_byte3,
    output logic [sfr_pkg::DIST_W-1:0]      o_distance_tenths,
    output logic [7:0]                      o_ready_flag,
    output logic [sfr_pkg::COUNT_W-1:0]     o_byte_count
);

    localparam int unsigned POS_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned KEEP_W = $clog2(sfr_pkg::KEPT_BYTES);

    logic                         r_filter_enable;
    logic [sfr_pkg::DIST_W-1:0]   r_jump_limit;

    logic [7:0]                   r_frame [sfr_pkg::KEPT_BYTES];
    logic [POS_W-1:0]             r_pos;
    logic [sfr_pkg::DIST_W-1:0]   r_last_dist;
    logic [7:0]                   r_code  [sfr_pkg::CODE_BYTES];
    logic [7:0]                   r_flag;

    logic                         r_out_valid;
    sfr_pkg::t_frame_type         r_type;

    sfr_pkg::t_frame_type         n_type;
    logic [sfr_pkg::DIST_W-1:0]   n_last_dist;
    logic [7:0]                   n_code  [sfr_pkg::CODE_BYTES];
    logic [7:0]                   n_flag;

    logic                         in_acc;
    logic                         idle_acc;
    logic                         byte_acc;
    logic [7:0]                   sum;
    logic [sfr_pkg::DIST_W-1:0]   data;
    logic [sfr_pkg::DIST_W:0]     diff_raw;
    logic [sfr_pkg::DIST_W-1:0]   diff;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (i_kind == sfr_pkg::KIND_BYTE) || !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign idle_acc    = in_acc && (i_kind == sfr_pkg::KIND_IDLE);
    assign byte_acc    = in_acc && (i_kind == sfr_pkg::KIND_BYTE);

    assign sum      = r_frame[0] + r_frame[1] + r_frame[2];
    assign data     = {r_frame[1], r_frame[2]};
    assign diff_raw = {1'b0, data} - {1'b0, r_last_dist};
    assign diff     = diff_raw[sfr_pkg::DIST_W] ? (r_last_dist - data) : diff_raw[sfr_pkg::DIST_W-1:0];

    always_comb begin
        n_type      = sfr_pkg::FT_UNKNOWN;
        n_last_dist = r_last_dist;
        n_code      = r_code;
        n_flag      = r_flag;
        priority if (r_frame[0] == sfr_pkg::HDR_CODE) begin
            n_code[0] = r_frame[1];
            n_code[1] = r_frame[2];
            n_code[2] = r_frame[3];
            n_code[3] = r_frame[4];
            n_type    = sfr_pkg::FT_CODE;
        end else if (r_frame[0] == sfr_pkg::HDR_DIST) begin
            n_flag = r_frame[4];
            if (sum == r_frame[3]) begin
                if (!r_filter_enable || (diff < r_jump_limit)) begin
                    n_last_dist = data;
                    n_type      = sfr_pkg::FT_DIST_OK;
                end else begin
                    n_type = sfr_pkg::FT_DIST_DROP;
                end
            end else begin
                n_type = sfr_pkg::FT_SUM_BAD;
            end
        end else begin
            n_type = sfr_pkg::FT_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= 1'b0;
            r_jump_limit    <= sfr_pkg::JUMP_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == sfr_pkg::CFG_FILTER_ENABLE) begin
                r_filter_enable <= i_cfg_data[0];
            end else if (i_cfg_index == sfr_pkg::CFG_JUMP_LIMIT) begin
                r_jump_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sfr_pkg::KEPT_BYTES; i++) begin
                r_frame[i] <= '0;
            end
            for (int i = 0; i < sfr_pkg::CODE_BYTES; i++) begin
                r_code[i] <= '0;
            end
            r_pos       <= '0;
            r_last_dist <= '0;
            r_flag      <= '0;
        end else if (byte_acc) begin
            if (r_pos < POS_W'(BUFFER_DEPTH)) begin
                if (r_pos < POS_W'(sfr_pkg::KEPT_BYTES)) begin
                    r_frame[r_pos[KEEP_W-1:0]] <= i_rx_byte;
                end
                r_pos <= r_pos + 1'b1;
            end
        end else if (idle_acc) begin
            r_pos       <= '0;
            r_last_dist <= n_last_dist;
            r_code      <= n_code;
            r_flag      <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (idle_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (idle_acc) begin
            r_type            <= n_type;
            o_code_byte0      <= n_code[0];
            o_code_byte1      <= n_code[1];
            o_code_byte2      <= n_code[2];
            o_code_byte3      <= n_code[3];
            o_distance_tenths <= n_last_dist;
            o_ready_flag      <= n_flag;
            o_byte_count      <= sfr_pkg::COUNT_W'(r_pos);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_type = r_type;

`ifndef SYNTH
    a_idle_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idle_acc |=> r_out_valid)
        else $error("idle transaction did not raise a result");

    a_idle_restarts_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idle_acc |=> (r_pos == '0))
        else $error("byte count not restarted after idle");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(BUFFER_DEPTH))
        else $error("byte position beyond buffer depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (idle_acc && r_out_valid) |-> i_out_ready)
        else $error("pending result overwritten");

    a_byte_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (byte_acc && !r_out_valid) |=> !r_out_valid)
        else $error("byte transaction produced a result");
`endif

endmodule
